### hdl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// shared constants, widths and the polynomial pipeline beat type for the
// fixed-point sine core
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int ANGLE_FRAC_BITS_DEF  = 24;
    localparam int RESULT_FRAC_BITS_DEF = 30;

    localparam int ANGLE_W  = 32;
    localparam int SINE_W   = 32;
    localparam int RED_BITS  = 44;
    localparam int POLY_BITS = 31;

    // widths of the reduction and polynomial datapath
    localparam int K_W   = 16;
    localparam int R_W   = 48;
    localparam int M_W   = 47;
    localparam int X_W   = 32;
    localparam int X2_W  = 33;
    localparam int ACC_W = 34;
    localparam int MAG_W = ACC_W - 1;

    localparam logic signed [30:0]      INV_TWO_PI_Q32 = 31'sd683565276;
    localparam logic signed [R_W-1:0]   TWO_PI_Q44     = 48'sd110534964875444;
    localparam logic [M_W-1:0]          PI_Q44         = 47'd55267482437722;
    localparam logic [M_W-1:0]          HALF_PI_Q44    = 47'd27633741218861;

    localparam logic signed [ACC_W-1:0] K1  = 34'sd2147483648;
    localparam logic signed [ACC_W-1:0] K3  = -34'sd357913939;
    localparam logic signed [ACC_W-1:0] K5  = 34'sd17895689;
    localparam logic signed [ACC_W-1:0] K7  = -34'sd426076;
    localparam logic signed [ACC_W-1:0] K9  = 34'sd5910;
    localparam logic signed [ACC_W-1:0] K11 = -34'sd51;

    localparam int HORNER_N = 5;
    localparam logic signed [ACC_W-1:0] HORNER_COEF [HORNER_N] = '{K9, K7, K5, K3, K1};

    typedef struct packed {
        logic [X_W-1:0]           x;
        logic [X2_W-1:0]          x2;
        logic                     neg;
        logic signed [ACC_W-1:0]  acc;
    } t_poly;

endpackage

### hdl/spa_reduce.sv
// ----------------------------------------------------------------------------
// spa_reduce
// range reduction to [-pi, pi], sign split, reflection about pi/2 and the
// square of the reduced angle, as a nine-stage pipeline
// ----------------------------------------------------------------------------
module spa_reduce #(
    parameter int ANGLE_FRAC_BITS = spa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    output logic                               o_rdy,
    input  logic signed [spa_pkg::ANGLE_W-1:0] i_angle,
    output logic                               o_vld,
    input  logic                               i_rdy,
    output spa_pkg::t_poly                     o_data
);
    import spa_pkg::*;

    localparam int N_STG   = 9;
    localparam int PROD_W  = ANGLE_W + 31;
    localparam int SH      = 32 + ANGLE_FRAC_BITS;
    localparam int K_OFF   = 1 << (62 - SH);
    localparam int RED_SH  = RED_BITS - ANGLE_FRAC_BITS;
    localparam int X_SH    = RED_BITS - POLY_BITS;
    localparam logic [63:0]   U_BIAS   = 64'd1 << 62;
    localparam logic [SH-1:0] HALF_REM = {1'b1, {(SH-1){1'b0}}};
    localparam logic [R_W-1:0] X_RND   = R_W'(1) << (X_SH - 1);
    localparam logic [64:0]   SQ_RND   = 65'd1 << (POLY_BITS - 1);

    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] n_rdy;
    logic [N_STG-1:0] n_vld_in;

    logic signed [PROD_W-1:0]  r0_prod;
    logic signed [ANGLE_W-1:0] r0_angle, r1_angle, r2_angle;
    logic signed [K_W-1:0]     r1_k;
    logic signed [63:0]        r2_kp;
    logic signed [R_W-1:0]     r3_r;
    logic                      r4_neg, r5_neg, r6_neg, r7_neg;
    logic [M_W-1:0]            r4_m, r5_m;
    logic [X_W-1:0]            r6_x, r7_x;
    logic [63:0]               r7_sq;
    t_poly                     r8_p;

    logic signed [63:0] n_pext;
    logic [63:0]        n_u;
    logic               n_up;
    logic [K_W:0]       n_kw;
    logic signed [63:0] n_r;
    logic [M_W-1:0]     n_m;
    logic               n_neg;

    // per-stage ready, a stage takes a beat when empty or when it drains
    always_comb begin
        n_rdy[N_STG-1] = !r_vld[N_STG-1] || i_rdy;
        for (int s = N_STG - 2; s >= 0; s--) begin
            n_rdy[s] = !r_vld[s] || n_rdy[s+1];
        end
    end

    assign n_vld_in = {r_vld[N_STG-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N_STG; s++) begin
                if (n_rdy[s]) begin
                    r_vld[s] <= n_vld_in[s];
                end
            end
        end
    end

    // nearest integer of angle/2pi, ties to even
    always_comb begin
        n_pext = 64'(r0_prod);
        n_u    = $unsigned(n_pext) + U_BIAS;
        n_up   = (n_u[SH-1:0] > HALF_REM) || ((n_u[SH-1:0] == HALF_REM) && n_u[SH]);
        n_kw   = (K_W+1)'(n_u >> SH) + (K_W+1)'(n_up) - (K_W+1)'(K_OFF);
        n_r    = (64'(r2_angle) <<< RED_SH) - r2_kp;
    end

    // fold magnitudes above pi/2 back into the first quadrant
    always_comb begin
        priority if (r4_m > PI_Q44) begin
            n_m   = r4_m - PI_Q44;
            n_neg = !r4_neg;
        end else if (r4_m > HALF_PI_Q44) begin
            n_m   = PI_Q44 - r4_m;
            n_neg = r4_neg;
        end else begin
            n_m   = r4_m;
            n_neg = r4_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[0]) begin
            r0_prod  <= i_angle * INV_TWO_PI_Q32;
            r0_angle <= i_angle;
        end
        if (n_rdy[1]) begin
            r1_k     <= $signed(n_kw[K_W-1:0]);
            r1_angle <= r0_angle;
        end
        if (n_rdy[2]) begin
            r2_kp    <= r1_k * TWO_PI_Q44;
            r2_angle <= r1_angle;
        end
        if (n_rdy[3]) begin
            r3_r <= n_r[R_W-1:0];
        end
        if (n_rdy[4]) begin
            r4_neg <= r3_r[R_W-1];
            r4_m   <= M_W'(r3_r[R_W-1] ? -r3_r : r3_r);
        end
        if (n_rdy[5]) begin
            r5_m   <= n_m;
            r5_neg <= n_neg;
        end
        if (n_rdy[6]) begin
            r6_x   <= X_W'((R_W'(r5_m) + X_RND) >> X_SH);
            r6_neg <= r5_neg;
        end
        if (n_rdy[7]) begin
            r7_sq  <= r6_x * r6_x;
            r7_x   <= r6_x;
            r7_neg <= r6_neg;
        end
        if (n_rdy[8]) begin
            r8_p.x   <= r7_x;
            r8_p.x2  <= X2_W'(({1'b0, r7_sq} + SQ_RND) >> POLY_BITS);
            r8_p.neg <= r7_neg;
            r8_p.acc <= K11;
        end
    end

    assign o_rdy  = n_rdy[0];
    assign o_vld  = r_vld[N_STG-1];
    assign o_data = r8_p;

endmodule

### hdl/spa_horner.sv
// ----------------------------------------------------------------------------
// spa_horner
// one horner step, acc <= coef + x2 * acc, product rounded to nearest with
// ties away from zero, in four pipeline stages
// ----------------------------------------------------------------------------
module spa_horner #(
    parameter logic signed [spa_pkg::ACC_W-1:0] COEF = spa_pkg::K9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  spa_pkg::t_poly i_data,
    output logic           o_vld,
    input  logic           i_rdy,
    output spa_pkg::t_poly o_data
);
    import spa_pkg::*;

    localparam int N_STG  = 4;
    localparam int PROD_W = X2_W + MAG_W;
    localparam logic [PROD_W:0] P_RND = (PROD_W+1)'(1) << (POLY_BITS - 1);

    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] n_rdy;
    logic [N_STG-1:0] n_vld_in;

    t_poly               r0_p, r1_p, r2_p, r3_p;
    logic                r0_aneg, r1_aneg, r2_aneg;
    logic [MAG_W-1:0]    r0_mag, r2_q;
    logic [PROD_W-1:0]   r1_prod;

    logic signed [ACC_W-1:0] n_qs;
    t_poly                   n_p;

    always_comb begin
        n_rdy[N_STG-1] = !r_vld[N_STG-1] || i_rdy;
        for (int s = N_STG - 2; s >= 0; s--) begin
            n_rdy[s] = !r_vld[s] || n_rdy[s+1];
        end
    end

    assign n_vld_in = {r_vld[N_STG-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N_STG; s++) begin
                if (n_rdy[s]) begin
                    r_vld[s] <= n_vld_in[s];
                end
            end
        end
    end

    assign n_qs = $signed({1'b0, r2_q});

    always_comb begin
        n_p     = r2_p;
        n_p.acc = r2_aneg ? (COEF - n_qs) : (COEF + n_qs);
    end

    // sign-magnitude multiply so the rounding is symmetric about zero
    always_ff @(posedge i_clk) begin
        if (n_rdy[0]) begin
            r0_p    <= i_data;
            r0_aneg <= i_data.acc[ACC_W-1];
            r0_mag  <= MAG_W'(i_data.acc[ACC_W-1] ? -i_data.acc : i_data.acc);
        end
        if (n_rdy[1]) begin
            r1_p    <= r0_p;
            r1_aneg <= r0_aneg;
            r1_prod <= r0_p.x2 * r0_mag;
        end
        if (n_rdy[2]) begin
            r2_p    <= r1_p;
            r2_aneg <= r1_aneg;
            r2_q    <= MAG_W'(({1'b0, r1_prod} + P_RND) >> POLY_BITS);
        end
        if (n_rdy[3]) begin
            r3_p <= n_p;
        end
    end

    assign o_rdy  = n_rdy[0];
    assign o_vld  = r_vld[N_STG-1];
    assign o_data = r3_p;

endmodule

### hdl/spa_output.sv
// ----------------------------------------------------------------------------
// spa_output
// final multiply by x, clamp below zero, rounding to the result format,
// saturation at one and the sign, in five pipeline stages
// ----------------------------------------------------------------------------
module spa_output #(
    parameter int RESULT_FRAC_BITS = spa_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    output logic                              o_rdy,
    input  spa_pkg::t_poly                    i_data,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output logic signed [spa_pkg::SINE_W-1:0] o_sine
);
    import spa_pkg::*;

    localparam int N_STG  = 5;
    localparam int PROD_W = X_W + MAG_W;
    localparam int Y_W    = PROD_W - POLY_BITS;
    localparam int RS     = POLY_BITS - RESULT_FRAC_BITS;
    localparam logic [PROD_W:0] P_RND   = (PROD_W+1)'(1) << (POLY_BITS - 1);
    localparam logic [Y_W:0]    RES_RND = (Y_W+1)'(1) << (RS - 1);
    localparam logic [Y_W-1:0]  ONE     = Y_W'(1) << RESULT_FRAC_BITS;

    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] n_rdy;
    logic [N_STG-1:0] n_vld_in;

    logic                r0_aneg, r1_aneg;
    logic                r0_neg, r1_neg, r2_neg, r3_neg;
    logic [X_W-1:0]      r0_x;
    logic [MAG_W-1:0]    r0_mag;
    logic [PROD_W-1:0]   r1_prod;
    logic [Y_W-1:0]      r2_y, r3_res;
    logic signed [SINE_W-1:0] r4_sine;

    logic [Y_W-1:0] n_sat;

    always_comb begin
        n_rdy[N_STG-1] = !r_vld[N_STG-1] || i_rdy;
        for (int s = N_STG - 2; s >= 0; s--) begin
            n_rdy[s] = !r_vld[s] || n_rdy[s+1];
        end
    end

    assign n_vld_in = {r_vld[N_STG-2:0], i_vld};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N_STG; s++) begin
                if (n_rdy[s]) begin
                    r_vld[s] <= n_vld_in[s];
                end
            end
        end
    end

    assign n_sat = (r3_res > ONE) ? ONE : r3_res;

    always_ff @(posedge i_clk) begin
        if (n_rdy[0]) begin
            r0_x    <= i_data.x;
            r0_neg  <= i_data.neg;
            r0_aneg <= i_data.acc[ACC_W-1];
            r0_mag  <= MAG_W'(i_data.acc[ACC_W-1] ? -i_data.acc : i_data.acc);
        end
        if (n_rdy[1]) begin
            r1_prod <= r0_x * r0_mag;
            r1_aneg <= r0_aneg;
            r1_neg  <= r0_neg;
        end
        if (n_rdy[2]) begin
            // a negative polynomial value clamps to zero
            r2_y   <= r1_aneg ? '0 : Y_W'(({1'b0, r1_prod} + P_RND) >> POLY_BITS);
            r2_neg <= r1_neg;
        end
        if (n_rdy[3]) begin
            r3_res <= Y_W'(({1'b0, r2_y} + RES_RND) >> RS);
            r3_neg <= r2_neg;
        end
        if (n_rdy[4]) begin
            r4_sine <= SINE_W'(r3_neg ? -n_sat : n_sat);
        end
    end

    assign o_rdy  = n_rdy[0];
    assign o_vld  = r_vld[N_STG-1];
    assign o_sine = r4_sine;

endmodule

### hdl/sine_polynomial_approx_core.sv
// ----------------------------------------------------------------------------
// sine_polynomial_approx_core
// fixed-point sine of an angle in radians by range reduction and an odd
// degree-11 polynomial
// ----------------------------------------------------------------------------
// usage:
// - input channel: i_valid, i_angle (radians, ANGLE_FRAC_BITS fraction bits),
//   o_stall back to the sender; a beat moves when i_valid is high and o_stall
//   is low
// - output channel: o_valid, o_sine (RESULT_FRAC_BITS fraction bits, clamped
//   to +/-1.0), i_stall from the receiver; one result beat per input beat, in
//   order
// - each beat passes the reduction and square, then the five horner steps,
//   then the final multiply, rounding and sign before its result appears
// - throughput is one beat per cycle while the receiver does not stall; each multiplier has a stage of its own
// - reset clears every stage valid, so no result appears until new beats go in
// - when the receiver stalls, the last stage holds its result and the stages
//   behind it keep filling empty slots, so beats are still taken until every
//   stage is full; only then does o_stall rise
// ----------------------------------------------------------------------------
module sine_polynomial_approx_core #(
    parameter int ANGLE_FRAC_BITS  = spa_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = spa_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [spa_pkg::ANGLE_W-1:0] i_angle,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [spa_pkg::SINE_W-1:0]  o_sine
);
    import spa_pkg::*;

    t_poly               w_poly [HORNER_N+1];
    logic [HORNER_N:0]   w_vld;
    logic [HORNER_N:0]   w_rdy;
    logic                w_in_rdy;

    spa_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_valid),
        .o_rdy   (w_in_rdy),
        .i_angle (i_angle),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_data  (w_poly[0])
    );

    for (genvar g = 0; g < HORNER_N; g++) begin : g_horner
        spa_horner #(
            .COEF(HORNER_COEF[g])
        ) u_horner (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_data  (w_poly[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_data  (w_poly[g+1])
        );
    end

    spa_output #(
        .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
    ) u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[HORNER_N]),
        .o_rdy   (w_rdy[HORNER_N]),
        .i_data  (w_poly[HORNER_N]),
        .o_vld   (o_valid),
        .i_rdy   (!i_stall),
        .o_sine  (o_sine)
    );

    assign o_stall = !w_in_rdy;

endmodule

### hdl/spa_checker.sv
// ----------------------------------------------------------------------------
// spa_checker
// port-level checks on the sine core, bound to the top level
// ----------------------------------------------------------------------------
module spa_checker #(
    parameter int RESULT_FRAC_BITS = spa_pkg::RESULT_FRAC_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [spa_pkg::SINE_W-1:0]  o_sine
);
    import spa_pkg::*;

    localparam logic signed [SINE_W-1:0] ONE = SINE_W'(1) << RESULT_FRAC_BITS;

    // nothing comes out of the pipe in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // back-pressure only reaches the input once a result is held at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_sine <= ONE) && (o_sine >= -ONE)))
        else $error("sine outside +/-1.0");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sine)))
        else $error("stalled result changed");

endmodule

bind sine_polynomial_approx_core spa_checker #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_spa_checker (.*);

### sim/sine_polynomial_approx_core_tb.sv
// ----------------------------------------------------------------------------
// sine_polynomial_approx_core_tb
// checks every result beat of the sine core against a bit-exact predictor:
// directed angles at the field extremes and the quadrant edges, then random
// angles under four idling phases on the sender and the receiver
// ----------------------------------------------------------------------------
module sine_polynomial_approx_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_FB  = spa_pkg::ANGLE_FRAC_BITS_DEF;
    localparam int RESULT_FB = spa_pkg::RESULT_FRAC_BITS_DEF;
    localparam int RED_FB    = spa_pkg::RED_BITS;
    localparam int POLY_FB   = spa_pkg::POLY_BITS;
    localparam int QUOT_SH   = 32 + ANGLE_FB;
    localparam int OUT_SH    = POLY_FB - RESULT_FB;

    localparam longint unsigned PI_RED      = spa_pkg::PI_Q44;
    localparam longint unsigned HALF_PI_RED = spa_pkg::HALF_PI_Q44;

    // pi and pi/2 at the angle format, rounded from the reduction constants
    localparam int PI_ANG      = int'((spa_pkg::PI_Q44 + (47'd1 << 19)) >> 20);
    localparam int HALF_PI_ANG = int'((spa_pkg::HALF_PI_Q44 + (47'd1 << 19)) >> 20);

    localparam int PIPE_LATENCY     = 34;
    localparam int DRAIN_CYCLES     = 2 * PIPE_LATENCY;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RANDOM_PER_PHASE = 188;
    localparam int MAX_REPORTS      = 50;

    typedef struct packed {
        logic signed [spa_pkg::ANGLE_W-1:0] angle;
        logic signed [spa_pkg::SINE_W-1:0]  sine;
    } t_sine_beat;

    logic                               i_clk;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic signed [spa_pkg::ANGLE_W-1:0] i_angle = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic signed [spa_pkg::SINE_W-1:0]  o_sine;

    t_sine_beat expected_sines[$];
    int         mismatch_count = 0;
    int         idle_cycles    = 0;
    int         tx_idle_pct    = 0;
    int         rx_stall_pct   = 0;

    sine_polynomial_approx_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_angle (i_angle),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_sine  (o_sine)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // q31 product, rounded to nearest with ties away from zero
    function automatic longint q31_mul(input longint a, input longint b);
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned prod;
        bit              flip;
        flip = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        prod = ua * ub;
        prod = (prod + (64'd1 << (POLY_FB - 1))) >> POLY_FB;
        return flip ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic logic signed [spa_pkg::SINE_W-1:0] predict_sine(
        input logic signed [spa_pkg::ANGLE_W-1:0] angle
    );
        longint          a;
        longint          quot;
        longint          turns;
        longint          red;
        longint          x;
        longint          x2;
        longint          acc;
        longint          y;
        longint unsigned biased;
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned mag;
        longint unsigned res;
        bit              neg;
        a = angle;

        // nearest whole number of turns, ties to even
        quot = a * longint'(spa_pkg::INV_TWO_PI_Q32);
        biased = quot + (64'd1 << 62);
        whole = biased >> QUOT_SH;
        frac = biased & ((64'd1 << QUOT_SH) - 64'd1);
        if (frac > (64'd1 << (QUOT_SH - 1)) ||
            (frac == (64'd1 << (QUOT_SH - 1)) && whole[0])) begin
            whole = whole + 64'd1;
        end
        turns = longint'(whole) - (longint'(1) << (62 - QUOT_SH));

        red = a * (longint'(1) << (RED_FB - ANGLE_FB))
              - turns * longint'(spa_pkg::TWO_PI_Q44);
        neg = red < 0;
        mag = neg ? -red : red;

        // fold into the first quadrant; past pi the sign flips
        if (mag > HALF_PI_RED) begin
            if (mag > PI_RED) begin
                mag = mag - PI_RED;
                neg = !neg;
            end else begin
                mag = PI_RED - mag;
            end
        end

        x = longint'((mag + (64'd1 << (RED_FB - POLY_FB - 1))) >> (RED_FB - POLY_FB));
        x2 = q31_mul(x, x);
        acc = longint'(spa_pkg::K11);
        for (int i = 0; i < spa_pkg::HORNER_N; i++) begin
            acc = longint'(spa_pkg::HORNER_COEF[i]) + q31_mul(x2, acc);
        end
        y = q31_mul(x, acc);
        if (y < 0) begin
            y = 0;
        end

        res = (unsigned'(y) + (64'd1 << (OUT_SH - 1))) >> OUT_SH;
        if (res > (64'd1 << RESULT_FB)) begin
            res = 64'd1 << RESULT_FB;
        end
        if (neg) begin
            res = -res;
        end
        return res[spa_pkg::SINE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input t_sine_beat want,
                                   input logic [spa_pkg::SINE_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: %s angle=%h sine got=%h expected=%h",
                     what, want.angle, got, want.sine);
        end
    endtask

    // one angle beat, after a random idle gap when the phase asks for one
    task automatic send_angle(input logic signed [spa_pkg::ANGLE_W-1:0] angle);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_angle <= angle;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic signed [spa_pkg::ANGLE_W-1:0] random_angle();
        int sel;
        int quarter;
        int offset;
        sel = $urandom_range(3);
        offset = int'($urandom_range(255)) - 128;
        case (sel)
            0, 1: begin
                return $urandom;
            end
            2: begin
                return int'($urandom_range(8 * PI_ANG)) - 4 * PI_ANG;
            end
            default: begin
                // close to a multiple of pi/2: saturation, folding and near-zero
                quarter = int'($urandom_range(160)) - 80;
                return quarter * HALF_PI_ANG + offset;
            end
        endcase
    endfunction

    task automatic test_field_extremes();
        send_angle(32'sd0);
        send_angle(32'sd1);
        send_angle(-32'sd1);
        send_angle(32'h7fff_ffff);
        send_angle(32'h8000_0000);
        send_angle(32'h5555_5555);
        send_angle(32'haaaa_aaaa);
        send_angle(32'h00ff_ffff);
    endtask

    task automatic test_quadrant_edges();
        send_angle(HALF_PI_ANG);
        send_angle(HALF_PI_ANG + 1);
        send_angle(HALF_PI_ANG - 1);
        send_angle(-HALF_PI_ANG);
        send_angle(PI_ANG);
        send_angle(PI_ANG + 1);
        send_angle(PI_ANG - 1);
        send_angle(-PI_ANG);
        send_angle(-PI_ANG - 1);
        send_angle(3 * PI_ANG);
        send_angle(3 * PI_ANG + 1);
        send_angle(2 * PI_ANG);
        send_angle(-2 * PI_ANG);
        send_angle(5 * PI_ANG - 1);
        send_angle(3 * HALF_PI_ANG);
    endtask

    task automatic test_random_angles(input int count);
        for (int n = 0; n < count; n++) begin
            send_angle(random_angle());
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct;
    end

    // predict on every accepted angle, compare on every accepted sine
    always @(posedge i_clk) begin
        t_sine_beat want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want.angle = i_angle;
                want.sine  = predict_sine(i_angle);
                expected_sines.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (expected_sines.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected beat", want, o_sine);
                end else begin
                    want = expected_sines.pop_front();
                    if (o_sine !== want.sine) begin
                        report_mismatch("wrong value", want, o_sine);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_quadrant_edges();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_random_angles(RANDOM_PER_PHASE);
        tx_idle_pct  = 75;
        rx_stall_pct = 0;
        test_random_angles(RANDOM_PER_PHASE);
        tx_idle_pct  = 0;
        rx_stall_pct = 75;
        test_random_angles(RANDOM_PER_PHASE);
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        test_random_angles(RANDOM_PER_PHASE);

        i_valid <= 1'b0;
        while (expected_sines.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sine_polynomial_approx_core.f
hdl/spa_pkg.sv
hdl/spa_reduce.sv
hdl/spa_horner.sv
hdl/spa_output.sv
hdl/sine_polynomial_approx_core.sv
hdl/spa_checker.sv
sim/sine_polynomial_approx_core_tb.sv
